/* hw/rtl/euler_to_quaternion_core_assert.svh */
// assertion macros for the euler to quaternion core
`ifndef EULER_TO_QUATERNION_CORE_ASSERT_SVH
`define EULER_TO_QUATERNION_CORE_ASSERT_SVH

`define E2Q_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`define E2Q_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

`endif

/* hw/rtl/e2q_pkg.sv */
`default_nettype none
package e2q_pkg;

   localparam int ANGLE_BITS   = 16;
   localparam int OUT_BITS     = 16;
   localparam int CORDIC_STEPS = 30;
   localparam int STEP_W       = 5;
   localparam int VAL_W        = 33;
   localparam int PHASE_W      = 36;
   localparam int SUM_W        = VAL_W + 1;
   localparam int RND_W        = 40;
   localparam int OUT_SH       = (OUT_BITS <= 31) ? 31 - OUT_BITS : 0;
   localparam logic signed [VAL_W-1:0] CORDIC_GAIN = VAL_W'(652032874);

   typedef struct packed {
      logic                            valid;
      logic [2:0][VAL_W-1:0]           x;
      logic [2:0][VAL_W-1:0]           y;
      logic [2:0][PHASE_W-1:0]         z;
   } e2q_cell_type;

   typedef struct packed {
      logic                            valid;
      logic [OUT_BITS-1:0]             qx;
      logic [OUT_BITS-1:0]             qy;
      logic [OUT_BITS-1:0]             qz;
      logic [OUT_BITS-1:0]             qw;
   } e2q_quat_type;

   function automatic logic [31:0] atan_tab(input logic [STEP_W-1:0] i);
      logic [31:0] r;
      case (i)
         5'd0: r = 32'h20000000;   5'd1: r = 32'h12E4051E;
         5'd2: r = 32'h09FB385B;   5'd3: r = 32'h051111D4;
         5'd4: r = 32'h028B0D43;   5'd5: r = 32'h0145D7E1;
         5'd6: r = 32'h00A2F61E;   5'd7: r = 32'h00517C55;
         5'd8: r = 32'h0028BE53;   5'd9: r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

   function automatic logic signed [VAL_W-1:0] mul_q30(input logic signed [VAL_W-1:0] a,
                                                       input logic signed [VAL_W-1:0] b);
      logic signed [2*VAL_W-1:0] p;
      p = a * b;
      p = p + (2*VAL_W)'(1 << 29);
      return p[VAL_W+29:30];
   endfunction

   function automatic logic [OUT_BITS-1:0] to_out(input logic signed [SUM_W-1:0] s);
      logic signed [RND_W-1:0] v;
      logic signed [RND_W-1:0] hi;
      logic signed [RND_W-1:0] lo;
      hi = (RND_W'(1) <<< (OUT_BITS - 1)) - RND_W'(1);
      lo = -hi - RND_W'(1);
      v  = RND_W'(s);
      v  = (v + ((RND_W'(1) <<< OUT_SH) >>> 1)) >>> OUT_SH;
      if (OUT_BITS > 31) v = v <<< 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[OUT_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/e2q_if.sv */
`default_nettype none
interface e2q_req_if import e2q_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [ANGLE_BITS-1:0]  roll_angle;
   logic signed [ANGLE_BITS-1:0]  pitch_angle;
   logic signed [ANGLE_BITS-1:0]  yaw_angle;
   modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
   modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface e2q_rsp_if import e2q_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [OUT_BITS-1:0]    quat_x;
   logic signed [OUT_BITS-1:0]    quat_y;
   logic signed [OUT_BITS-1:0]    quat_z;
   logic signed [OUT_BITS-1:0]    quat_w;
   modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
   modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface
`default_nettype wire

/* hw/rtl/e2q_cordic_cell.sv */
`default_nettype none
module e2q_cordic_cell import e2q_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                enable,
   input  wire logic [STEP_W-1:0]   step,
   input  wire e2q_cell_type        cell_in,
   output e2q_cell_type             cell_out
);

   e2q_cell_type cell_ff, cell_in_nxt;
   logic signed [PHASE_W-1:0] ang;

   always_comb begin
      cell_in_nxt       = cell_in;
      ang               = PHASE_W'(atan_tab(step)) <<< 2;
      for (int k = 0; k < 3; k++) begin
         if (!cell_in.z[k][PHASE_W-1]) begin
            cell_in_nxt.x[k] = $signed(cell_in.x[k]) - ($signed(cell_in.y[k]) >>> step);
            cell_in_nxt.y[k] = $signed(cell_in.y[k]) + ($signed(cell_in.x[k]) >>> step);
            cell_in_nxt.z[k] = $signed(cell_in.z[k]) - ang;
         end else begin
            cell_in_nxt.x[k] = $signed(cell_in.x[k]) + ($signed(cell_in.y[k]) >>> step);
            cell_in_nxt.y[k] = $signed(cell_in.y[k]) - ($signed(cell_in.x[k]) >>> step);
            cell_in_nxt.z[k] = $signed(cell_in.z[k]) + ang;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (enable) begin
         cell_ff.valid <= cell_in_nxt.valid;
      end
      if (enable) begin
         cell_ff.x <= cell_in_nxt.x;
         cell_ff.y <= cell_in_nxt.y;
         cell_ff.z <= cell_in_nxt.z;
      end
   end

   assign cell_out = cell_ff;

endmodule
`default_nettype wire

/* hw/rtl/e2q_quat_mul.sv */
`default_nettype none
module e2q_quat_mul import e2q_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          enable,
   input  wire e2q_cell_type  trig_in,
   output e2q_quat_type       quat_out
);

   logic signed [VAL_W-1:0] sr, cr, sp, cp, sy, cy;
   logic                    v1_ff, v2_ff, v3_ff;
   logic signed [VAL_W-1:0] sc_ff, cs_ff, cc_ff, ss_ff, sy_ff, cy_ff;
   logic signed [VAL_W-1:0] t_ff [8];
   logic [OUT_BITS-1:0]     qx_ff, qy_ff, qz_ff, qw_ff;

   assign sr = trig_in.y[0];
   assign cr = trig_in.x[0];
   assign sp = trig_in.y[1];
   assign cp = trig_in.x[1];
   assign sy = trig_in.y[2];
   assign cy = trig_in.x[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= trig_in.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (enable) begin
         sc_ff <= mul_q30(sr, cp);
         cs_ff <= mul_q30(cr, sp);
         cc_ff <= mul_q30(cr, cp);
         ss_ff <= mul_q30(sr, sp);
         sy_ff <= sy;
         cy_ff <= cy;
         t_ff[0] <= mul_q30(sc_ff, cy_ff);
         t_ff[1] <= mul_q30(cs_ff, sy_ff);
         t_ff[2] <= mul_q30(cs_ff, cy_ff);
         t_ff[3] <= mul_q30(sc_ff, sy_ff);
         t_ff[4] <= mul_q30(cc_ff, sy_ff);
         t_ff[5] <= mul_q30(ss_ff, cy_ff);
         t_ff[6] <= mul_q30(cc_ff, cy_ff);
         t_ff[7] <= mul_q30(ss_ff, sy_ff);
         qx_ff <= to_out(SUM_W'(t_ff[0]) - SUM_W'(t_ff[1]));
         qy_ff <= to_out(SUM_W'(t_ff[2]) + SUM_W'(t_ff[3]));
         qz_ff <= to_out(SUM_W'(t_ff[4]) - SUM_W'(t_ff[5]));
         qw_ff <= to_out(SUM_W'(t_ff[6]) + SUM_W'(t_ff[7]));
      end
   end

   always_comb begin
      quat_out.valid = v3_ff;
      quat_out.qx    = qx_ff;
      quat_out.qy    = qy_ff;
      quat_out.qz    = qz_ff;
      quat_out.qw    = qw_ff;
   end

endmodule
`default_nettype wire

/* hw/rtl/euler_to_quaternion_core.sv */
// Euler angles (roll, pitch, yaw, Z-Y-X order) to unit quaternion.
// req_chan: valid/ready transfer of roll_angle, pitch_angle, yaw_angle as
// signed binary angles, full scale +/- pi.
// rsp_chan: valid/ready transfer of quat_x, quat_y, quat_z, quat_w in Q1.15,
// an exact +1.0 saturating to the largest positive code.
// One result per request, in request order.
// Pipeline from request transfer to rsp valid: 30 CORDIC cells,
// each one rotation step for all three half angles, then two multiply
// stages and a rounding stage.
// Throughput: one transfer per cycle while the receiver does not stall; the row
// of cells and the multipliers are fully pipelined.
// Reset clears all stage valid flags; no result is pending afterwards.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and req ready is low until that result is taken.
`default_nettype none
`include "euler_to_quaternion_core_assert.svh"
module euler_to_quaternion_core import e2q_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   e2q_req_if.sink    req_chan,
   e2q_rsp_if.source  rsp_chan
);

   logic         enable;
   e2q_cell_type chain [CORDIC_STEPS+1];
   e2q_quat_type quat;

   assign enable         = !quat.valid || rsp_chan.ready;
   assign req_chan.ready = enable;

   always_comb begin
      chain[0].valid = req_chan.valid;
      for (int k = 0; k < 3; k++) begin
         chain[0].x[k] = CORDIC_GAIN;
         chain[0].y[k] = '0;
      end
      chain[0].z[0] = PHASE_W'(req_chan.roll_angle) <<< (33 - ANGLE_BITS);
      chain[0].z[1] = PHASE_W'(req_chan.pitch_angle) <<< (33 - ANGLE_BITS);
      chain[0].z[2] = PHASE_W'(req_chan.yaw_angle) <<< (33 - ANGLE_BITS);
   end

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
      e2q_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .step     (STEP_W'(g)),
         .cell_in  (chain[g]),
         .cell_out (chain[g+1])
      );
   end

   e2q_quat_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .trig_in  (chain[CORDIC_STEPS]),
      .quat_out (quat)
   );

   assign rsp_chan.valid  = quat.valid;
   assign rsp_chan.quat_x = quat.qx;
   assign rsp_chan.quat_y = quat.qy;
   assign rsp_chan.quat_z = quat.qz;
   assign rsp_chan.quat_w = quat.qw;

   `E2Q_ASSERT_NOW(a_stall_blocks_req, rsp_chan.valid && !rsp_chan.ready, !req_chan.ready, "request taken while result stalled")
   `E2Q_ASSERT_NEXT(a_stall_holds_w, rsp_chan.valid && !rsp_chan.ready, rsp_chan.valid && $stable(rsp_chan.quat_w), "stalled result changed")
   `E2Q_ASSERT_NEXT(a_cell_advance, enable && chain[CORDIC_STEPS].valid, u_mul.v1_ff, "trig result lost")

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
module tb;
   import e2q_pkg::*;

   localparam int CLK_HALF   = 10;
   localparam int STALL_MAX  = 4000;
   localparam int LATENCY    = 33;
   localparam int N_RANDOM   = 600;

   typedef struct packed {
      logic [OUT_BITS-1:0] qx;
      logic [OUT_BITS-1:0] qy;
      logic [OUT_BITS-1:0] qz;
      logic [OUT_BITS-1:0] qw;
   } quat_type;

   logic clock;
   logic reset;
   int   errors;
   int   idle_cycles;
   bit   rsp_stall_en;

   quat_type pending_quats[$];

   e2q_req_if req_chan ();
   e2q_rsp_if rsp_chan ();

   euler_to_quaternion_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   // long signed arithmetic helpers, 64 bit
   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint q30_mul(longint a, longint b);
      return floor_shr(a * b + (longint'(1) << 29), 30);
   endfunction

   function automatic longint atan_step(int i);
      longint t[CORDIC_STEPS] = '{
         'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
         'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
         'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2FA,
         'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
         'h0000028C, 'h00000146, 'h000000A3, 'h00000051, 'h00000029,
         'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001};
      return t[i];
   endfunction

   task automatic half_angle_sincos(input logic signed [ANGLE_BITS-1:0] ang,
                                    output longint s, output longint c);
      longint z, x, y, dx, dy;
      z = longint'(ang) * (longint'(1) << (33 - ANGLE_BITS));
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = floor_shr(y, i);
         dy = floor_shr(x, i);
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - atan_step(i) * 4;
         end else begin
            x = x + dx; y = y - dy; z = z + atan_step(i) * 4;
         end
      end
      s = y;
      c = x;
   endtask

   function automatic longint triple(longint a, longint b, longint c);
      return q30_mul(q30_mul(a, b), c);
   endfunction

   function automatic logic [OUT_BITS-1:0] round_sat(longint v);
      longint hi, lo;
      int sh;
      hi = (longint'(1) << (OUT_BITS - 1)) - 1;
      lo = -hi - 1;
      sh = 31 - OUT_BITS;
      if (OUT_BITS <= 31) begin
         if (sh > 0) v = floor_shr(v + (longint'(1) << (sh - 1)), sh);
      end else begin
         v = v * 2;
      end
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[OUT_BITS-1:0];
   endfunction

   task automatic predict_quat(input logic [ANGLE_BITS-1:0] r, input logic [ANGLE_BITS-1:0] p,
                               input logic [ANGLE_BITS-1:0] yw, output quat_type q);
      longint sr, cr, sp, cp, sy, cy;
      half_angle_sincos(r, sr, cr);
      half_angle_sincos(p, sp, cp);
      half_angle_sincos(yw, sy, cy);
      q.qx = round_sat(triple(sr, cp, cy) - triple(cr, sp, sy));
      q.qy = round_sat(triple(cr, sp, cy) + triple(sr, cp, sy));
      q.qz = round_sat(triple(cr, cp, sy) - triple(sr, sp, cy));
      q.qw = round_sat(triple(cr, cp, cy) + triple(sr, sp, sy));
   endtask

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // called at a falling edge; valid stays high into the next transfer unless a gap is drawn
   task automatic send_angles(input logic [ANGLE_BITS-1:0] r, input logic [ANGLE_BITS-1:0] p,
                              input logic [ANGLE_BITS-1:0] yw, input bit gaps);
      quat_type q;
      int g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_chan.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      predict_quat(r, p, yw, q);
      req_chan.valid       <= 1'b1;
      req_chan.roll_angle  <= r;
      req_chan.pitch_angle <= p;
      req_chan.yaw_angle   <= yw;
      do @(posedge clock); while (!req_chan.ready);
      pending_quats.push_back(q);
      @(negedge clock);
   endtask

   // result sink
   int rsp_hold;
   always @(negedge clock) begin
      if (reset || !rsp_stall_en) begin
         rsp_chan.ready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_hold <= gap_len();
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      quat_type q;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_quats.size() == 0) begin
            errors++;
            $display("%0t: unexpected result x=%h y=%h z=%h w=%h", $time, rsp_chan.quat_x,
                     rsp_chan.quat_y, rsp_chan.quat_z, rsp_chan.quat_w);
         end else begin
            q = pending_quats.pop_front();
            if (rsp_chan.quat_x !== q.qx) begin
               errors++;
               $display("%0t: quat_x expected %h actual %h", $time, q.qx, rsp_chan.quat_x);
            end
            if (rsp_chan.quat_y !== q.qy) begin
               errors++;
               $display("%0t: quat_y expected %h actual %h", $time, q.qy, rsp_chan.quat_y);
            end
            if (rsp_chan.quat_z !== q.qz) begin
               errors++;
               $display("%0t: quat_z expected %h actual %h", $time, q.qz, rsp_chan.quat_z);
            end
            if (rsp_chan.quat_w !== q.qw) begin
               errors++;
               $display("%0t: quat_w expected %h actual %h", $time, q.qw, rsp_chan.quat_w);
            end
         end
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
         $display("[euler_to_quaternion_core] ERROR");
         $finish;
      end
   end

   task automatic test_extremes();
      logic [ANGLE_BITS-1:0] v[6] = '{16'h0000, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF,
                                      16'h4000};
      for (int i = 0; i < 6; i++) send_angles(v[i], v[i], v[i], 1'b0);
      send_angles(16'h8000, 16'h0000, 16'h0000, 1'b0);
      send_angles(16'h0000, 16'h8000, 16'h0000, 1'b0);
      send_angles(16'h0000, 16'h0000, 16'h8000, 1'b0);
      send_angles(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
      send_angles(16'h8000, 16'h7FFF, 16'h8000, 1'b0);
      send_angles(16'hC000, 16'h4000, 16'hC000, 1'b0);
      send_angles(16'h5555, 16'hAAAA, 16'h5555, 1'b0);
      send_angles(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
   endtask

   task automatic test_back_to_back();
      for (int i = 0; i < 100; i++)
         send_angles(ANGLE_BITS'($urandom), ANGLE_BITS'($urandom), ANGLE_BITS'($urandom),
                     1'b0);
   endtask

   task automatic test_random_gaps();
      rsp_stall_en = 1'b1;
      for (int i = 0; i < N_RANDOM - 100; i++)
         send_angles(ANGLE_BITS'($urandom), ANGLE_BITS'($urandom), ANGLE_BITS'($urandom),
                     1'b1);
   endtask

   initial begin
      errors = 0;
      rsp_stall_en = 1'b0;
      rsp_hold = 0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.roll_angle = '0;
      req_chan.pitch_angle = '0;
      req_chan.yaw_angle = '0;
      rsp_chan.ready = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_extremes();
      test_back_to_back();
      test_random_gaps();
      req_chan.valid <= 1'b0;
      while (pending_quats.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0 && pending_quats.size() == 0)
         $display("[euler_to_quaternion_core] OK");
      else
         $display("[euler_to_quaternion_core] ERROR");
      $finish;
   end
endmodule
